// File: rtl/pse_pkg.sv
`default_nettype none
package pse_pkg;
   localparam int STACK_DEPTH = 32;
   localparam int PTR_W = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W = $clog2(STACK_DEPTH);

   typedef enum logic [3:0] {
      OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3, OP_MOD = 4'd4,
      OP_AND = 4'd5, OP_OR = 4'd6, OP_XOR = 4'd7, OP_SHL = 4'd8, OP_SHR = 4'd9,
      OP_POW = 4'd10, OP_CAT = 4'd11, OP_MAX = 4'd12, OP_REP = 4'd13
   } op_type;

   typedef enum logic [1:0] {
      ERR_NONE = 2'd0, ERR_DIVZERO = 2'd1, ERR_UNDERFLOW = 2'd2, ERR_OVERFLOW = 2'd3
   } err_type;

   typedef struct packed {
      logic        start;
      logic [3:0]  op;
      logic [31:0] a;
      logic [31:0] b;
   } alu_cmd_type;

   typedef struct packed {
      logic        done;
      logic        divzero;
      logic [31:0] result;
   } alu_rsp_type;

   function automatic logic [31:0] mag(input logic [31:0] v);
      mag = v[31] ? (32'd0 - v) : v;
   endfunction
endpackage
`default_nettype wire

// File: rtl/pse_if.sv
`default_nettype none
interface pse_req_if;
   logic        valid;
   logic        ready;
   logic        mode;
   logic [3:0]  opcode;
   logic [31:0] operand;
   logic        last;
   modport source (output valid, mode, opcode, operand, last, input ready);
   modport sink (input valid, mode, opcode, operand, last, output ready);
endinterface

interface pse_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] value;
   logic [1:0]  error;
   modport source (output valid, value, error, input ready);
   modport sink (input valid, value, error, output ready);
endinterface
`default_nettype wire

// File: rtl/postfix_stack_evaluator_top.sv
`default_nettype none
// Postfix expression evaluator.
// req carries one token per word: mode 0 pushes operand, mode 1 applies opcode
// to the two top entries of a 32-entry stack held in a synchronous memory.
// rsp gives one word per token marked last: the bottom entry and the sticky
// error code; the stack and error are then cleared.
// Pushes can follow back to back; an operator goes through two memory reads,
// the ALU pass and the write back, multiply too; divide and modulo compute
// one quotient bit per cycle (a zero divisor skips the division steps), power
// steps once per exponent bit, at least once, and concatenation steps once
// per decimal digit of b. The ALU and the memory read port set the length
// of each operator. A last token then reads the bottom entry and hands over
// the word, which waits for as long as rsp.ready stays low.
// Reset clears the stack pointer and error code; stack contents are not
// cleared and need no clearing pass. A result waits in the rsp register while
// rsp.ready is low; no new token is taken until it has gone.
module postfix_stack_evaluator_top
   import pse_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   pse_req_if.sink  req,
   pse_rsp_if.source rsp
);
   typedef enum logic [2:0] {S_IDLE, S_RDA, S_RDB, S_ALU, S_WAIT, S_LAST, S_OUT} state_type;

   state_type    state_ff;
   logic [31:0]  mem [STACK_DEPTH];
   logic [31:0]  rdata_ff, a_ff, b_ff;
   logic [ADDR_W-1:0] raddr;
   logic [PTR_W-1:0] sp_ff;
   logic [1:0]   err_ff;
   logic [3:0]   op_ff;
   logic         last_ff;
   logic         we;
   logic [ADDR_W-1:0] waddr;
   logic [31:0]  wdata;
   alu_cmd_type  cmd;
   alu_rsp_type  arsp;

   pse_alu u_alu (.clock(clock), .reset(reset), .cmd(cmd), .rsp(arsp));

   assign req.ready = (state_ff == S_IDLE);

   always_comb begin
      we = 1'b0;
      waddr = sp_ff[ADDR_W-1:0];
      wdata = req.operand;
      raddr = '0;
      case (state_ff)
         S_IDLE: begin
            we = req.valid && req.mode == 1'b0 && sp_ff < PTR_W'(STACK_DEPTH);
            raddr = ADDR_W'(sp_ff - PTR_W'(2));
         end
         S_RDA: raddr = ADDR_W'(sp_ff - PTR_W'(1));
         S_WAIT: begin
            we = arsp.done;
            waddr = ADDR_W'(sp_ff - PTR_W'(2));
            wdata = arsp.result;
         end
         default: raddr = '0;
      endcase
      cmd.start = (state_ff == S_ALU);
      cmd.op = op_ff;
      cmd.a = a_ff;
      cmd.b = b_ff;
   end

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata_ff <= mem[raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff <= '0;
         err_ff <= ERR_NONE;
         rsp.valid <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: if (req.valid) begin
               last_ff <= req.last;
               op_ff <= req.opcode;
               if (req.mode == 1'b0) begin
                  if (sp_ff >= PTR_W'(STACK_DEPTH)) begin
                     if (err_ff == ERR_NONE) err_ff <= ERR_OVERFLOW;
                  end else sp_ff <= sp_ff + PTR_W'(1);
                  state_ff <= req.last ? S_LAST : S_IDLE;
               end else if (sp_ff < PTR_W'(2)) begin
                  if (err_ff == ERR_NONE) err_ff <= ERR_UNDERFLOW;
                  state_ff <= req.last ? S_LAST : S_IDLE;
               end else state_ff <= S_RDA;
            end
            S_RDA: begin
               a_ff <= rdata_ff;
               state_ff <= S_RDB;
            end
            S_RDB: begin
               b_ff <= rdata_ff;
               state_ff <= S_ALU;
            end
            S_ALU: state_ff <= S_WAIT;
            S_WAIT: if (arsp.done) begin
               sp_ff <= sp_ff - PTR_W'(1);
               if (arsp.divzero && err_ff == ERR_NONE) err_ff <= ERR_DIVZERO;
               state_ff <= last_ff ? S_LAST : S_IDLE;
            end
            S_LAST: state_ff <= S_OUT;
            S_OUT: if (!rsp.valid) begin
               rsp.valid <= 1'b1;
               rsp.value <= (sp_ff == '0) ? 32'd0 : rdata_ff;
               rsp.error <= (sp_ff == '0 && err_ff == ERR_NONE) ? ERR_UNDERFLOW : err_ff;
               sp_ff <= '0;
               err_ff <= ERR_NONE;
            end else if (rsp.ready) begin
               rsp.valid <= 1'b0;
               state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_sp_range: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= PTR_W'(STACK_DEPTH)) else $error("stack pointer out of range");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> !req.ready) else $error("token taken with result pending");
   a_alu_done: assert property (@(posedge clock) disable iff (reset)
      arsp.done |-> state_ff == S_WAIT) else $error("alu done out of turn");
`endif
endmodule
`default_nettype wire

// File: rtl/pse_alu.sv
`default_nettype none
module pse_alu
   import pse_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  alu_cmd_type cmd,
   output alu_rsp_type rsp
);
   typedef enum logic [2:0] {S_IDLE, S_DIV, S_POW, S_CAT, S_DONE} state_type;

   state_type   state_ff;
   logic [3:0]  op_ff;
   logic [31:0] a_ff, b_ff, res_ff, acc_ff, base_ff, rem_ff, quo_ff, cnt_ff;
   logic [5:0]  step_ff;
   logic        dz_ff;
   logic [32:0] trial;
   logic [31:0] simple;
   logic [31:0] qs, rs;
   logic [31:0] sa;
   logic [63:0] prod10;

   always_comb begin
      sa = a_ff;
      simple = b_ff;
      case (op_ff)
         OP_ADD: simple = a_ff + b_ff;
         OP_SUB: simple = a_ff - b_ff;
         OP_AND: simple = a_ff & b_ff;
         OP_OR:  simple = a_ff | b_ff;
         OP_XOR: simple = a_ff ^ b_ff;
         OP_SHL: simple = (b_ff >= 32'd32) ? 32'd0 : (a_ff << b_ff[4:0]);
         OP_SHR: simple = (b_ff >= 32'd32) ? {32{a_ff[31]}} :
                          32'($signed(sa) >>> b_ff[4:0]);
         OP_MAX: simple = (a_ff[31] != b_ff[31]) ? (a_ff[31] ? b_ff : a_ff) :
                          ((a_ff > b_ff) ? a_ff : b_ff);
         default: simple = b_ff;
      endcase
      trial = {rem_ff, quo_ff[31]} - {1'b0, mag(b_ff)};
      qs = (a_ff[31] != b_ff[31]) ? (32'd0 - quo_ff) : quo_ff;
      rs = a_ff[31] ? (32'd0 - rem_ff) : rem_ff;
      prod10 = {32'd0, cnt_ff} * 64'h0000_0000_CCCC_CCCD;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp.done <= 1'b0;
      end else begin
         rsp.done <= 1'b0;
         case (state_ff)
            S_IDLE: if (cmd.start) begin
               op_ff <= cmd.op;
               a_ff <= cmd.a;
               b_ff <= cmd.b;
               dz_ff <= 1'b0;
               rem_ff <= 32'd0;
               quo_ff <= mag(cmd.a);
               step_ff <= 6'd0;
               acc_ff <= 32'd1;
               base_ff <= cmd.a;
               cnt_ff <= mag(cmd.b);
               res_ff <= cmd.a;
               if (cmd.op == OP_DIV || cmd.op == OP_MOD)
                  state_ff <= (cmd.b == 32'd0) ? S_DONE : S_DIV;
               else if (cmd.op == OP_POW) state_ff <= S_POW;
               else if (cmd.op == OP_CAT) state_ff <= S_CAT;
               else if (cmd.op == OP_MUL) begin
                  res_ff <= cmd.a * cmd.b;
                  state_ff <= S_DONE;
               end else state_ff <= S_DONE;
               if ((cmd.op == OP_DIV || cmd.op == OP_MOD) && cmd.b == 32'd0)
                  dz_ff <= 1'b1;
            end
            S_DIV: begin
               if (!trial[32]) begin
                  rem_ff <= trial[31:0];
                  quo_ff <= {quo_ff[30:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[30:0], quo_ff[31]};
                  quo_ff <= {quo_ff[30:0], 1'b0};
               end
               step_ff <= step_ff + 6'd1;
               if (step_ff == 6'd31) state_ff <= S_DONE;
            end
            S_POW: begin
               if (b_ff[31]) begin
                  acc_ff <= (a_ff == 32'd1) ? 32'd1 :
                            (a_ff == 32'hFFFFFFFF) ? (b_ff[0] ? 32'hFFFFFFFF : 32'd1) : 32'd0;
                  state_ff <= S_DONE;
               end else begin
                  if (b_ff[0]) acc_ff <= acc_ff * base_ff;
                  base_ff <= base_ff * base_ff;
                  b_ff <= b_ff >> 1;
                  if (b_ff[31:1] == 31'd0) state_ff <= S_DONE;
               end
            end
            S_CAT: begin
               res_ff <= res_ff * 32'd10;
               cnt_ff <= {3'd0, prod10[63:35]};
               if (cnt_ff < 32'd10) state_ff <= S_DONE;
            end
            default: begin
               rsp.done <= 1'b1;
               rsp.divzero <= dz_ff;
               state_ff <= S_IDLE;
               case (op_ff)
                  OP_MUL: rsp.result <= res_ff;
                  OP_DIV: rsp.result <= dz_ff ? 32'd0 : qs;
                  OP_MOD: rsp.result <= dz_ff ? 32'd0 : rs;
                  OP_POW: rsp.result <= acc_ff;
                  OP_CAT: rsp.result <= res_ff + b_ff;
                  default: rsp.result <= simple;
               endcase
            end
         endcase
      end
   end
endmodule
`default_nettype wire

// File: bench/postfix_stack_evaluator_check.sv
`timescale 1ns / 1ps
module postfix_stack_evaluator_check
   import pse_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   pse_req_if       req,
   pse_rsp_if       rsp,
   output int       fail_count,
   output int       results_pending
);

   typedef struct {
      logic [31:0] value;
      err_type     error;
   } result_type;

   logic [31:0] stack_mem [STACK_DEPTH];
   int          depth;
   err_type     sticky_err;
   result_type  expected_results [$];

   assign results_pending = expected_results.size();

   function automatic logic [31:0] evaluate(input logic [3:0] op, input logic [31:0] a,
                                            input logic [31:0] b, output logic div_zero);
      logic [31:0] ma, mb, acc, base, e, v, m;
      ma       = a[31] ? -a : a;
      mb       = b[31] ? -b : b;
      div_zero = 1'b0;
      case (op)
         OP_ADD: return a + b;
         OP_SUB: return a - b;
         OP_MUL: return a * b;
         OP_DIV, OP_MOD: begin
            if (b == 0) begin
               div_zero = 1'b1;
               return 32'd0;
            end
            if (op == OP_DIV) begin
               v = ma / mb;
               return (a[31] != b[31]) ? -v : v;
            end
            v = ma % mb;
            return a[31] ? -v : v;
         end
         OP_AND: return a & b;
         OP_OR:  return a | b;
         OP_XOR: return a ^ b;
         OP_SHL: return (b >= 32) ? 32'd0 : a << b[4:0];
         OP_SHR: return (b >= 32) ? {32{a[31]}} : $unsigned($signed(a) >>> b[4:0]);
         OP_POW: begin
            if (b[31]) begin
               if (a == 32'd1) return 32'd1;
               if (a == 32'hFFFF_FFFF) return b[0] ? 32'hFFFF_FFFF : 32'd1;
               return 32'd0;
            end
            acc  = 32'd1;
            base = a;
            e    = b;
            while (e != 0) begin
               if (e[0]) acc = acc * base;
               base = base * base;
               e    = e >> 1;
            end
            return acc;
         end
         OP_CAT: begin
            m = mb;
            v = a;
            do begin
               m = m / 10;
               v = v * 10;
            end while (m != 0);
            return v + b;
         end
         OP_MAX: begin
            if (a[31] != b[31]) return a[31] ? b : a;
            return (a > b) ? a : b;
         end
         default: return b;
      endcase
   endfunction

   function automatic void flag(input err_type code);
      if (sticky_err == ERR_NONE) sticky_err = code;
   endfunction

   function automatic void take_token(input logic mode, input logic [3:0] op,
                                      input logic [31:0] operand, input logic last);
      logic       dz;
      result_type r;
      if (!mode) begin
         if (depth >= STACK_DEPTH) flag(ERR_OVERFLOW);
         else begin
            stack_mem[depth] = operand;
            depth++;
         end
      end else if (depth < 2) begin
         flag(ERR_UNDERFLOW);
      end else begin
         stack_mem[depth-2] = evaluate(op, stack_mem[depth-2], stack_mem[depth-1], dz);
         depth--;
         if (dz) flag(ERR_DIVZERO);
      end
      if (last) begin
         r.value = 32'd0;
         if (depth == 0) flag(ERR_UNDERFLOW);
         else r.value = stack_mem[0];
         r.error = sticky_err;
         expected_results.push_back(r);
         depth      = 0;
         sticky_err = ERR_NONE;
      end
   endfunction

   always @(posedge clock) begin
      result_type r;
      if (reset) begin
         depth      = 0;
         sticky_err = ERR_NONE;
         fail_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (expected_results.size() == 0) begin
               $error("unexpected result word: value %h error %0d", rsp.value, rsp.error);
               fail_count++;
            end else begin
               r = expected_results.pop_front();
               if (rsp.value !== r.value) begin
                  $error("value: expected %h, got %h", r.value, rsp.value);
                  fail_count++;
               end
               if (rsp.error !== r.error) begin
                  $error("error: expected %0d, got %0d", r.error, rsp.error);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready) take_token(req.mode, req.opcode, req.operand, req.last);
      end
   end

endmodule

// File: bench/postfix_stack_evaluator_top_test.sv
`timescale 1ns / 1ps
module postfix_stack_evaluator_top_test;
   import pse_pkg::*;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int TOKEN_TARGET   = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, results_pending;
   int   idle_cycles = 0;
   int   tokens_sent = 0;
   int   burst_left = 0;
   int   hold_left = 0;
   int   cycle_count = 0;

   pse_req_if req ();
   pse_rsp_if rsp ();

   postfix_stack_evaluator_top i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp));

   postfix_stack_evaluator_check i_check (
      .clock(clock), .reset(reset), .req(req), .rsp(rsp),
      .fail_count(fail_count), .results_pending(results_pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      req.valid   = 1'b0;
      req.mode    = 1'b0;
      req.opcode  = 4'd0;
      req.operand = 32'd0;
      req.last    = 1'b0;
      rsp.ready   = 1'b0;
   end

   // receiver: own stall pattern, with one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count == 3000) hold_left = 600;
         if (hold_left > 0) begin
            hold_left--;
            rsp.ready <= 1'b0;
         end else if ((cycle_count / 500) % 3 == 0) begin
            rsp.ready <= 1'b1;
         end else begin
            rsp.ready <= ($urandom_range(0, 3) != 0);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAIL postfix_stack_evaluator_top");
         $finish;
      end else idle_cycles <= idle_cycles + 1;
   end

   task automatic send(input logic mode, input logic [3:0] op, input logic [31:0] operand,
                       input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         gap        = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
         repeat (gap) begin
            req.valid <= 1'b0;
            @(posedge clock);
         end
      end
      burst_left--;
      req.valid   <= 1'b1;
      req.mode    <= mode;
      req.opcode  <= op;
      req.operand <= operand;
      req.last    <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      tokens_sent++;
   endtask

   function automatic logic [31:0] pick_operand();
      case ($urandom_range(0, 5))
         0, 1: return $urandom;
         2:    return 32'($urandom_range(0, 108)) - 32'd9;
         3:    return 32'($urandom_range(0, 40));
         4: begin
            case ($urandom_range(0, 4))
               0: return 32'h8000_0000;
               1: return 32'h7FFF_FFFF;
               2: return 32'hFFFF_FFFF;
               3: return 32'd1;
               default: return 32'd0;
            endcase
         end
         default: return -32'($urandom_range(1, 40));
      endcase
   endfunction

   task automatic random_expression();
      int len, d;
      logic noisy, mode, last;
      len   = $urandom_range(1, 14);
      noisy = ($urandom_range(0, 9) == 0);
      d     = 0;
      for (int i = 0; i < len; i++) begin
         last = (i == len - 1);
         if (noisy) mode = 1'($urandom_range(0, 1));
         else if (d < 2) mode = 1'b0;
         else if (last) mode = 1'b1;
         else mode = (d < 31) ? 1'($urandom_range(0, 1)) : 1'b1;
         if (mode) d = (d >= 2) ? d - 1 : d;
         else d = (d < STACK_DEPTH) ? d + 1 : d;
         send(mode, 4'($urandom_range(0, 15)), pick_operand(), last);
      end
   endtask

   task automatic binary(input logic [31:0] a, input logic [31:0] b, input logic [3:0] op);
      send(1'b0, OP_ADD, a, 1'b0);
      send(1'b0, OP_ADD, b, 1'b0);
      send(1'b1, op, 32'd0, 1'b1);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      binary(32'h7FFF_FFFF, 32'h8000_0000, OP_ADD);
      binary(32'h8000_0000, 32'hFFFF_FFFF, OP_DIV);
      binary(32'h8000_0000, 32'hFFFF_FFFF, OP_MOD);
      binary(32'd17, 32'd0, OP_DIV);
      binary(-32'd7, 32'd0, OP_MOD);
      binary(-32'd100, 32'hFFFF_FFF0, OP_SHR);
      binary(32'd5, 32'hFFFF_FFFF, OP_SHL);
      binary(32'hFFFF_FFFF, -32'd3, OP_POW);
      binary(32'd12, -32'd345, OP_CAT);
      binary(-32'd1, 32'd1, OP_MAX);
      binary(32'd3, 32'd9, 4'd15);
      send(1'b1, OP_ADD, 32'd0, 1'b1);
      binary(32'd1, 32'd0, OP_DIV);
      send(1'b1, OP_SUB, 32'd0, 1'b1);
      for (int i = 0; i <= STACK_DEPTH; i++) send(1'b0, OP_ADD, 32'(i), i == STACK_DEPTH);
      for (int k = 0; k < 16; k++) binary(pick_operand(), pick_operand(), 4'(k));

      while (tokens_sent < TOKEN_TARGET) random_expression();
      req.valid <= 1'b0;

      while (results_pending != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0) $display("PASS postfix_stack_evaluator_top");
      else $display("FAIL postfix_stack_evaluator_top");
      $finish;
   end

endmodule
